// File: rtl/core/reb_pkg.sv
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types and constants for the debounced rotary encoder with button.
// ----------------------------------------------------------------------------
package reb_pkg;

   // Field widths
   localparam int BtnTimerWidth   = 16;
   localparam int PhaseTimerWidth = 8;
   localparam int CountWidth      = 8;
   localparam int WordWidth       = 2 * CountWidth;

   // Register file geometry
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;

   typedef logic [BtnTimerWidth-1:0]   btn_timer_type;
   typedef logic [PhaseTimerWidth-1:0] phase_timer_type;
   typedef logic [CountWidth-1:0]      count_type;
   typedef logic [WordWidth-1:0]       word_type;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [0:0] {
      REG_BUTTON_SETTLE = 1'b0,
      REG_PHASE_SETTLE  = 1'b1
   } reg_index_type;

   // Reset values of the registers
   localparam btn_timer_type   BTN_SETTLE_RESET   = 16'd10;
   localparam phase_timer_type PHASE_SETTLE_RESET = 8'd1;

endpackage

// File: rtl/core/reb_req_if.sv
// ----------------------------------------------------------------------------
// reb_req_if
// Input channel: one beat per sampling tick with raw pin levels.
// ----------------------------------------------------------------------------
interface reb_req_if;

   logic valid;
   logic ready;
   logic button_level;
   logic phase_a_level;
   logic phase_b_level;
   logic clear_request;

   modport source (
      output valid, button_level, phase_a_level, phase_b_level, clear_request,
      input  ready
   );

   modport sink (
      input  valid, button_level, phase_a_level, phase_b_level, clear_request,
      output ready
   );

endinterface

// File: rtl/core/reb_rsp_if.sv
// ----------------------------------------------------------------------------
// reb_rsp_if
// Result channel: one beat per tick carrying the packed count word.
// ----------------------------------------------------------------------------
interface reb_rsp_if
   import reb_pkg::*;
();

   logic     valid;
   logic     ready;
   word_type packed_word;

   modport source (
      output valid, packed_word,
      input  ready
   );

   modport sink (
      input  valid, packed_word,
      output ready
   );

endinterface

// File: rtl/core/rotary_encoder_with_button.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_button
// Debounced push button and quadrature encoder with press and position counts.
// ----------------------------------------------------------------------------
// Each input beat is one sampling tick and yields exactly one result beat.
// A beat is registered in the input register; the debounce filters, the
// decoder and the counters then update when the packed word is loaded into
// the output register, which can stall while a result waits. The result is
// offered from the output register. The block takes one beat per clock cycle
// as long as the output register frees up; the two-entry path (input
// register, output register) can accept one more beat while a result waits.
// The two settle thresholds sit in an APB-style register file (button at
// 0x0, phase at 0x4); the user must write them only while no tick is in
// flight, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rotary_encoder_with_button
   import reb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   reb_req_if.sink                 req_ch,
   reb_rsp_if.source               rsp_ch,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // Configuration registers
   btn_timer_type   btn_settle_ff;
   phase_timer_type phase_settle_ff;
   reg_index_type   csr_index;
   logic            csr_write;

   // Input register
   logic s1_valid_ff;
   logic s1_btn_ff, s1_pa_ff, s1_pb_ff, s1_clr_ff;

   // Filter and counter state
   logic            btn_stable_ff, a_filt_ff, b_filt_ff, a_prev_ff, b_prev_ff;
   btn_timer_type   btn_timer_ff;
   phase_timer_type a_timer_ff, b_timer_ff;
   count_type       press_ff, pos_ff;

   logic            btn_stable_in, a_filt_in, b_filt_in, a_prev_in, b_prev_in;
   btn_timer_type   btn_timer_in;
   phase_timer_type a_timer_in, b_timer_in;
   count_type       press_in, pos_in;
   logic            btn_accept, a_accept, b_accept;

   // Output register
   logic     out_valid_ff;
   word_type out_word_ff;
   word_type out_word_in;

   // Handshake
   logic out_load;
   logic s1_load;

   // ---- Register file ----
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_index)
         REG_BUTTON_SETTLE: begin
            prdata = {{(CsrDataWidth-BtnTimerWidth){1'b0}}, btn_settle_ff};
         end
         REG_PHASE_SETTLE: begin
            prdata = {{(CsrDataWidth-PhaseTimerWidth){1'b0}}, phase_settle_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_settle_ff   <= BTN_SETTLE_RESET;
         phase_settle_ff <= PHASE_SETTLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_BUTTON_SETTLE: begin
               btn_settle_ff <= pwdata[BtnTimerWidth-1:0];
            end
            REG_PHASE_SETTLE: begin
               phase_settle_ff <= pwdata[PhaseTimerWidth-1:0];
            end
            default: begin
               btn_settle_ff <= btn_settle_ff;
            end
         endcase
      end
   end

   // ---- Flow control: output register frees, input register drains ----
   assign out_load     = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign s1_load      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_btn_ff <= req_ch.button_level;
         s1_pa_ff  <= req_ch.phase_a_level;
         s1_pb_ff  <= req_ch.phase_b_level;
         s1_clr_ff <= req_ch.clear_request;
      end
   end

   // ---- Debounce filters: timer holds on agreement, clears on accept ----
   always_comb begin
      btn_timer_type   btn_inc;
      phase_timer_type a_inc;
      phase_timer_type b_inc;

      btn_inc = btn_timer_ff + 1'b1;
      a_inc   = a_timer_ff + 1'b1;
      b_inc   = b_timer_ff + 1'b1;

      btn_accept = (s1_btn_ff != btn_stable_ff) && (btn_inc > btn_settle_ff);
      a_accept   = (s1_pa_ff != a_filt_ff) && (a_inc > phase_settle_ff);
      b_accept   = (s1_pb_ff != b_filt_ff) && (b_inc > phase_settle_ff);

      btn_timer_in  = btn_timer_ff;
      btn_stable_in = btn_stable_ff;
      if (s1_btn_ff != btn_stable_ff) begin
         btn_timer_in = btn_accept ? '0 : btn_inc;
      end
      if (btn_accept) begin
         btn_stable_in = s1_btn_ff;
      end

      a_timer_in = a_timer_ff;
      a_filt_in  = a_filt_ff;
      if (s1_pa_ff != a_filt_ff) begin
         a_timer_in = a_accept ? '0 : a_inc;
      end
      if (a_accept) begin
         a_filt_in = s1_pa_ff;
      end

      b_timer_in = b_timer_ff;
      b_filt_in  = b_filt_ff;
      if (s1_pb_ff != b_filt_ff) begin
         b_timer_in = b_accept ? '0 : b_inc;
      end
      if (b_accept) begin
         b_filt_in = s1_pb_ff;
      end
   end

   // ---- Decoder and counters; A change wins over a B change ----
   always_comb begin
      press_in  = press_ff;
      pos_in    = pos_ff;
      a_prev_in = a_prev_ff;
      b_prev_in = b_prev_ff;

      if (btn_accept && !s1_btn_ff) begin
         press_in = press_ff + 1'b1;
      end

      if (a_filt_in != a_prev_ff) begin
         if (!b_prev_ff && !a_filt_in) begin
            pos_in = pos_ff + 1'b1;
         end
         a_prev_in = a_filt_in;
      end else if (b_filt_in != b_prev_ff) begin
         if (!a_prev_ff && !b_filt_in) begin
            pos_in = pos_ff - 1'b1;
         end
         b_prev_in = b_filt_in;
      end

      if (s1_clr_ff) begin
         press_in    = '0;
         pos_in      = '0;
         out_word_in = '0;
      end else begin
         out_word_in = {press_in, pos_in};
      end
   end

   // ---- State update, one tick per loaded beat ----
   always_ff @(posedge clock) begin
      if (reset) begin
         btn_stable_ff <= 1'b0;
         btn_timer_ff  <= '0;
         a_filt_ff     <= 1'b0;
         b_filt_ff     <= 1'b0;
         a_timer_ff    <= '0;
         b_timer_ff    <= '0;
         a_prev_ff     <= 1'b0;
         b_prev_ff     <= 1'b0;
         press_ff      <= '0;
         pos_ff        <= '0;
      end else if (out_load) begin
         btn_stable_ff <= btn_stable_in;
         btn_timer_ff  <= btn_timer_in;
         a_filt_ff     <= a_filt_in;
         b_filt_ff     <= b_filt_in;
         a_timer_ff    <= a_timer_in;
         b_timer_ff    <= b_timer_in;
         a_prev_ff     <= a_prev_in;
         b_prev_ff     <= b_prev_in;
         press_ff      <= press_in;
         pos_ff        <= pos_in;
      end
   end

   // ---- Output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.packed_word = out_word_ff;

endmodule

// File: tb/sv/reb_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reb_tb_pkg
// Tracks the debounce filters, the quadrature decoder and both counters, and
// holds the packed words the encoder block must return, oldest first.
// ----------------------------------------------------------------------------
package reb_tb_pkg;

   import reb_pkg::*;

   class encoder_tracker;

      // Settle thresholds as last written
      btn_timer_type   button_limit;
      phase_timer_type phase_limit;

      // Filter, decoder and counter state
      logic            button_stable;
      btn_timer_type   button_timer;
      logic            a_stable;
      logic            b_stable;
      phase_timer_type a_timer;
      phase_timer_type b_timer;
      logic            a_seen;
      logic            b_seen;
      count_type       presses;
      count_type       position;

      word_type        expected_words[$];
      int              mismatches;

      function new();
         button_limit  = BTN_SETTLE_RESET;
         phase_limit   = PHASE_SETTLE_RESET;
         button_stable = 1'b0;
         button_timer  = '0;
         a_stable      = 1'b0;
         b_stable      = 1'b0;
         a_timer       = '0;
         b_timer       = '0;
         a_seen        = 1'b0;
         b_seen        = 1'b0;
         presses       = '0;
         position      = '0;
         mismatches    = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            REG_BUTTON_SETTLE: button_limit = value[BtnTimerWidth-1:0];
            REG_PHASE_SETTLE:  phase_limit  = value[PhaseTimerWidth-1:0];
            default: ;
         endcase
      endfunction

      // Phase filter: timer only moves while the sample disagrees, wraps at 8 bits
      function void settle_phase(input logic sample, inout logic stable,
                                 inout phase_timer_type timer);
         if (sample != stable) begin
            timer = timer + 1'b1;
            if (timer > phase_limit) begin
               timer  = '0;
               stable = sample;
            end
         end
      endfunction

      // One accepted tick: update state and queue the word it must produce
      function void note_tick(logic btn, logic pa, logic pb, logic clr);
         if (btn != button_stable) begin
            button_timer = button_timer + 1'b1;
            if (button_timer > button_limit) begin
               button_timer  = '0;
               button_stable = btn;
               if (!btn) presses = presses + 1'b1;
            end
         end

         settle_phase(pa, a_stable, a_timer);
         settle_phase(pb, b_stable, b_timer);

         // A change wins; a B change waits for a tick without one
         if (a_stable != a_seen) begin
            if (!b_seen && !a_stable) position = position + 1'b1;
            a_seen = a_stable;
         end else if (b_stable != b_seen) begin
            if (!a_seen && !b_stable) position = position - 1'b1;
            b_seen = b_stable;
         end

         if (clr) begin
            presses  = '0;
            position = '0;
            expected_words.push_back('0);
         end else begin
            expected_words.push_back({presses, position});
         end
      endfunction

      function void check_word(word_type got);
         word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: packed_word %h arrived with nothing pending", $time, got);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got !== want) begin
            $display("%0t: packed_word mismatch: expected %h, actual %h",
                     $time, want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

   endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sampled button and encoder levels into the rotary encoder block under
// random flow control, retunes the settle thresholds between phases and checks
// every packed word against a tracking model of the filters and counters.
// ----------------------------------------------------------------------------
module tb_top;

   import reb_pkg::*;
   import reb_tb_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   int                      long_hold_requests;
   encoder_tracker          sb;

   reb_req_if req_ch ();
   reb_rsp_if rsp_ch ();

   rotary_encoder_with_button u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // How long a level is held: usually long enough to settle, sometimes a bounce
   function automatic int hold_len(int limit);
      int n;
      if ($urandom_range(0, 9) < 7) n = limit + 1 + $urandom_range(0, 3);
      else n = $urandom_range(1, limit + 1);
      if (n > 600) n = 600;
      return n;
   endfunction

   task automatic send_tick(logic btn, logic pa, logic pb, logic clr, int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.button_level  <= btn;
      req_ch.phase_a_level <= pa;
      req_ch.phase_b_level <= pb;
      req_ch.clear_request <= clr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_tick(btn, pa, pb, clr);
   endtask

   task automatic release_input();
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CsrDataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // New thresholds only once the pipe is empty
   task automatic retune(int button_ticks, int phase_ticks);
      release_input();
      drain_results();
      repeat (4) @(posedge clock);
      csr_write(REG_BUTTON_SETTLE, CsrDataWidth'(button_ticks));
      csr_write(REG_PHASE_SETTLE, CsrDataWidth'(phase_ticks));
   endtask

   // Both phases at once, a plain step, button timer holding through agreement,
   // position wrap below zero, a press, then clears
   task automatic run_directed();
      logic [3:0] seq [26];
      int         k;
      seq = '{4'b1110, 4'b1110, 4'b1110, 4'b1000, 4'b1000, 4'b1000,
              4'b0100, 4'b0100, 4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000,
              4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
              4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
              4'b1111, 4'b0001};
      for (k = 0; k < 26; k++)
         send_tick(seq[k][3], seq[k][2], seq[k][1], seq[k][0], pick_gap());
   endtask

   // Mostly clean quadrature steps and button presses held near the settle
   // time, with bounces, bursts of pure noise and rare clears
   task automatic run_ticks(int count, int pause_at, int hold_at);
      int   k;
      int   btn_left;
      int   enc_left;
      int   noise_left;
      int   calm_left;
      int   step;
      int   dir;
      int   gap;
      logic btn_lvl;
      logic bi;
      logic ai;
      logic bbi;
      logic ci;
      btn_left   = 0;
      enc_left   = 0;
      noise_left = 0;
      calm_left  = 0;
      step       = 0;
      dir        = 1;
      btn_lvl    = 1'($urandom);
      for (k = 0; k < count; k++) begin
         if (k == pause_at) begin
            release_input();
            drain_results();
         end
         // Receiver goes quiet while the sender keeps pushing
         if (k == hold_at) begin
            long_hold_requests++;
            calm_left = 600;
         end

         if (noise_left == 0 && $urandom_range(0, 99) < 3)
            noise_left = $urandom_range(5, 40);
         if (noise_left > 0) begin
            noise_left--;
            bi  = 1'($urandom);
            ai  = 1'($urandom);
            bbi = 1'($urandom);
         end else begin
            if (btn_left == 0) begin
               btn_lvl  = ~btn_lvl;
               btn_left = hold_len(int'(sb.button_limit));
            end
            btn_left--;
            if (enc_left == 0) begin
               if ($urandom_range(0, 9) == 0) dir = -dir;
               step     = (step + dir + 4) % 4;
               enc_left = hold_len(int'(sb.phase_limit));
            end
            enc_left--;
            bi  = btn_lvl;
            ai  = (step == 1 || step == 2);
            bbi = (step == 2 || step == 3);
            if ($urandom_range(0, 24) == 0) bi  = ~bi;
            if ($urandom_range(0, 24) == 0) ai  = ~ai;
            if ($urandom_range(0, 24) == 0) bbi = ~bbi;
         end
         ci = ($urandom_range(0, 149) == 0);

         if (calm_left > 0) begin
            calm_left--;
            gap = 0;
         end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 100);
         end
         send_tick(bi, ai, bbi, ci, gap);
      end
   endtask

   // Result side: random stalls, free-flowing stretches, one long hold-off
   initial begin : result_sink
      int stall_left;
      int flow_left;
      int g;
      int holds_seen;
      stall_left   = 0;
      flow_left    = 0;
      holds_seen   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_word(rsp_ch.packed_word);
         if (long_hold_requests != holds_seen) begin
            holds_seen = long_hold_requests;
            stall_left = 400;
            flow_left  = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (flow_left > 0) begin
            flow_left--;
            rsp_ch.ready <= 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            flow_left = $urandom_range(20, 100);
            rsp_ch.ready <= 1'b1;
         end else begin
            g          = pick_gap();
            stall_left = (g > 0) ? g - 1 : 0;
            rsp_ch.ready <= (g == 0);
         end
      end
   end

   initial begin : stimulus
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.button_level  = 1'b0;
      req_ch.phase_a_level = 1'b0;
      req_ch.phase_b_level = 1'b0;
      req_ch.clear_request = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      long_hold_requests   = 0;
      sb                   = new();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset thresholds first, then fastest, mid, slowest and another mid
      run_directed();
      run_ticks(200, 100, -1);
      retune(0, 0);
      run_ticks(300, -1, 20);
      retune(3, 2);
      run_ticks(300, -1, -1);
      retune(65534, 254);
      run_ticks(300, -1, -1);
      retune(20, 5);
      run_ticks(250, -1, -1);

      release_input();
      drain_results();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
rtl/core/reb_pkg.sv
rtl/core/reb_req_if.sv
rtl/core/reb_rsp_if.sv
rtl/core/rotary_encoder_with_button.sv
tb/sv/reb_tb_pkg.sv
tb/sv/tb_top.sv
